FILE: src/blade_element_aero_coefficients_core_macros.svh
// Assertion macros for the blade element coefficient core.
`ifndef BLADE_ELEMENT_AERO_COEFFICIENTS_CORE_MACROS_SVH
`define BLADE_ELEMENT_AERO_COEFFICIENTS_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define BEC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BEC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BEC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define BEC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: src/bec_pkg.sv
// Shared constants, types and tables of the blade element coefficient core.
package bec_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 12;

  localparam int VT_W = 25;   // tangential speed, 1/256 m/s
  localparam int X_W  = 36;   // CORDIC x/y datapath
  localparam int Z_W  = 33;   // CORDIC angle, Q30

  localparam int FRONT_STAGES = 4;
  localparam int BACK_STAGES  = 4;

  localparam logic [15:0] RADIUS_RESET = 16'd2560;
  localparam logic        REG_RADIUS   = 1'b0;

  localparam logic [20:0] OMEGA_Q24    = 21'd1756906;
  localparam logic [23:0] INV_GAIN_Q24 = 24'd10188013;
  localparam logic signed [45:0] DEG2RAD_Q40 = 46'sd74961321;
  localparam logic signed [36:0] TWO_PI_Q16  = 37'sd411775;
  localparam logic signed [30:0] NEG_MOMENT_Q16 = -31'sd6554;
  localparam logic [45:0] DRAG_K_Q16 = 46'd3277;
  localparam logic [45:0] DRAG_C_Q40 = 46'd10995116278;
  localparam logic [15:0] DRAG_MIN   = 16'd41;

  // Side data that rides along the CORDIC stages
  typedef struct packed {
    logic signed [16:0] pt;     // pitch + twist, 1/256 degree
    logic               zero;   // tangential and vertical speed both zero
  } side_t;

  // Arctangent of 2^-i in Q30
  function automatic logic [30:0] atan_q30(input int unsigned idx);
    logic [30:0] v;
    case (idx)
      0:  v = 31'd843314857;
      1:  v = 31'd497837829;
      2:  v = 31'd263043837;
      3:  v = 31'd133525159;
      4:  v = 31'd67021687;
      5:  v = 31'd33543516;
      6:  v = 31'd16775851;
      7:  v = 31'd8388437;
      8:  v = 31'd4194283;
      9:  v = 31'd2097149;
      10: v = 31'd1048576;
      11: v = 31'd524288;
      12: v = 31'd262144;
      13: v = 31'd131072;
      14: v = 31'd65536;
      15: v = 31'd32768;
      16: v = 31'd16384;
      17: v = 31'd8192;
      18: v = 31'd4096;
      19: v = 31'd2048;
      20: v = 31'd1024;
      21: v = 31'd512;
      22: v = 31'd256;
      23: v = 31'd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/blade_element_aero_coefficients_core.sv
// Throughput: one item per cycle unless the result stalls; each stage moves as
// soon as the next has room, so bubbles close up while the result register waits.
// The two CORDIC pipelines run side by side, one micro-rotation per stage.
// Reset clears all stage valid bits and sets the radius register to 2560.
// Top level of the blade element coefficient core.
`include "blade_element_aero_coefficients_core_macros.svh"

module blade_element_aero_coefficients_core #(
  parameter int CORDIC_STEPS    = bec_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = bec_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // item channel
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [15:0]        rotor_rpm,
  input  logic signed [15:0] fwd_airspeed,
  input  logic signed [15:0] vert_airspeed,
  input  logic [15:0]        radial_fraction,
  input  logic signed [15:0] pitch_deg,
  input  logic signed [15:0] twist_deg,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic [23:0]        resultant_speed,
  output logic signed [16:0] attack_angle,
  output logic signed [18:0] lift_coef,
  output logic [15:0]        drag_coef,
  output logic signed [16:0] moment_coef
);

  localparam int FN = bec_pkg::FRONT_STAGES;
  localparam int S  = FN + CORDIC_STEPS + bec_pkg::BACK_STAGES;

  logic [15:0]                    blade_radius;
  logic [S-1:0]                   valid;
  logic [S-1:0]                   adv;
  logic [bec_pkg::VT_W-1:0]       vt;
  logic [16:0]                    fwd_abs;
  logic signed [15:0]             vert;
  logic signed [16:0]             pt;
  logic signed [bec_pkg::X_W-1:0] x0;
  logic signed [bec_pkg::X_W-1:0] y_mag;
  logic signed [bec_pkg::X_W-1:0] y_ang;
  logic signed [bec_pkg::X_W-1:0] xm;
  logic signed [bec_pkg::Z_W-1:0] inflow;
  bec_pkg::side_t                 side_q [CORDIC_STEPS];

  // Register write and read back
  always_ff @(posedge clk) begin
    if (rst) begin
      blade_radius <= bec_pkg::RADIUS_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == bec_pkg::REG_RADIUS) begin
      blade_radius <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == bec_pkg::REG_RADIUS) ? {16'd0, blade_radius} : '0;

  // Stage advance: a stage loads when it is empty or the next one advances
  always_comb begin
    adv[S-1] = !valid[S-1] || !result_stall;
    for (int k = S - 2; k >= 0; k--) begin
      adv[k] = !valid[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) begin
        valid[0] <= item_valid;
      end
      for (int k = 1; k < S; k++) begin
        if (adv[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign item_stall   = !adv[0];
  assign result_valid = valid[S-1];

  bec_front u_front (
    .clk             (clk),
    .en              (adv[FN-1:0]),
    .rotor_rpm       (rotor_rpm),
    .fwd_airspeed    (fwd_airspeed),
    .vert_airspeed   (vert_airspeed),
    .radial_fraction (radial_fraction),
    .pitch_deg       (pitch_deg),
    .twist_deg       (twist_deg),
    .radius          (blade_radius),
    .vt              (vt),
    .fwd_abs         (fwd_abs),
    .vert            (vert),
    .pt              (pt)
  );

  // Scale CORDIC inputs by 2^8
  assign x0    = bec_pkg::X_W'({vt, 8'd0});
  assign y_mag = bec_pkg::X_W'({fwd_abs, 8'd0});
  assign y_ang = bec_pkg::X_W'(vert) <<< 8;

  bec_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_mag (
    .clk   (clk),
    .en    (adv[FN +: CORDIC_STEPS]),
    .x_in  (x0),
    .y_in  (y_mag),
    .x_out (xm),
    .z_out ()
  );

  bec_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_ang (
    .clk   (clk),
    .en    (adv[FN +: CORDIC_STEPS]),
    .x_in  (x0),
    .y_in  (y_ang),
    .x_out (),
    .z_out (inflow)
  );

  // Carry pitch sum and zero-vector flag alongside the rotations
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv[FN+i]) begin
        if (i == 0) begin
          side_q[i].pt   <= pt;
          side_q[i].zero <= (vt == '0) && (vert == '0);
        end else begin
          side_q[i] <= side_q[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  bec_back #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_back (
    .clk             (clk),
    .en              (adv[FN+CORDIC_STEPS +: bec_pkg::BACK_STAGES]),
    .xm              (xm),
    .inflow          (inflow),
    .side            (side_q[CORDIC_STEPS-1]),
    .resultant_speed (resultant_speed),
    .attack_angle    (attack_angle),
    .lift_coef       (lift_coef),
    .drag_coef       (drag_coef),
    .moment_coef     (moment_coef)
  );

  // Input held off only when every stage is full and the result is stalled
  `BEC_ASSERT_IMP(a_stall_full, clk, rst, item_stall, (&valid) && result_stall, "input stalled with room in pipeline")
  // Accepted transfer lands in the first stage
  `BEC_ASSERT_NXT(a_accept_lands, clk, rst, item_valid && !item_stall, valid[0], "accepted item lost at entry")
  // Drag never drops below its constant term
  `BEC_ASSERT_IMP(a_drag_floor, clk, rst, result_valid, drag_coef >= bec_pkg::DRAG_MIN, "drag below constant term")
  // Moment opposes a positive angle of attack
  `BEC_ASSERT_IMP(a_moment_sign, clk, rst, result_valid && attack_angle > 17'sd0, moment_coef <= 17'sd0, "moment sign wrong")

endmodule

FILE: src/bec_front.sv
// Front stages: tangential speed from rpm, radial fraction and radius.
module bec_front (
  input  logic                              clk,
  input  logic [bec_pkg::FRONT_STAGES-1:0]  en,
  input  logic [15:0]                       rotor_rpm,
  input  logic signed [15:0]                fwd_airspeed,
  input  logic signed [15:0]                vert_airspeed,
  input  logic [15:0]                       radial_fraction,
  input  logic signed [15:0]                pitch_deg,
  input  logic signed [15:0]                twist_deg,
  input  logic [15:0]                       radius,
  output logic [bec_pkg::VT_W-1:0]          vt,
  output logic [16:0]                       fwd_abs,
  output logic signed [15:0]                vert,
  output logic signed [16:0]                pt
);

  logic [31:0]        a_p1;
  logic [16:0]        a_fabs;
  logic signed [15:0] a_vert;
  logic signed [16:0] a_pt;
  logic [47:0]        b_p;
  logic [16:0]        b_fabs;
  logic signed [15:0] b_vert;
  logic signed [16:0] b_pt;
  logic [44:0]        c_mh;
  logic [44:0]        c_ml;
  logic [16:0]        c_fabs;
  logic signed [15:0] c_vert;
  logic signed [16:0] c_pt;
  logic signed [16:0] fwd_ext;
  logic [45:0]        vt_sum;

  assign fwd_ext = 17'(fwd_airspeed);

  // Stage A: rpm times fraction, fold forward speed to magnitude
  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_p1   <= 32'(rotor_rpm) * 32'(radial_fraction);
      a_fabs <= fwd_airspeed[15] ? 17'(-fwd_ext) : 17'(fwd_ext);
      a_vert <= vert_airspeed;
      a_pt   <= 17'(pitch_deg) + 17'(twist_deg);
    end
  end

  // Stage B: times radius
  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_p    <= 48'(a_p1) * 48'(radius);
      b_fabs <= a_fabs;
      b_vert <= a_vert;
      b_pt   <= a_pt;
    end
  end

  // Stage C: angular rate constant, split into upper and lower halves
  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_mh   <= 45'(b_p[47:24]) * 45'(bec_pkg::OMEGA_Q24);
      c_ml   <= 45'(b_p[23:0]) * 45'(bec_pkg::OMEGA_Q24);
      c_fabs <= b_fabs;
      c_vert <= b_vert;
      c_pt   <= b_pt;
    end
  end

  assign vt_sum = 46'(c_mh) + 46'(c_ml[44:24]);

  // Stage D: combine halves and drop the fraction
  always_ff @(posedge clk) begin
    if (en[3]) begin
      vt      <= vt_sum[44:20];
      fwd_abs <= c_fabs;
      vert    <= c_vert;
      pt      <= c_pt;
    end
  end

endmodule

FILE: src/bec_cordic.sv
// Vectoring CORDIC, one micro-rotation per register stage.
module bec_cordic #(
  parameter int STEPS = bec_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic [STEPS-1:0]                  en,
  input  logic signed [bec_pkg::X_W-1:0]    x_in,
  input  logic signed [bec_pkg::X_W-1:0]    y_in,
  output logic signed [bec_pkg::X_W-1:0]    x_out,
  output logic signed [bec_pkg::Z_W-1:0]    z_out
);

  logic signed [bec_pkg::X_W-1:0] xs [STEPS];
  logic signed [bec_pkg::X_W-1:0] ys [STEPS];
  logic signed [bec_pkg::Z_W-1:0] zs [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [bec_pkg::Z_W-1:0] ATAN =
      bec_pkg::Z_W'(bec_pkg::atan_q30(i));
    logic signed [bec_pkg::X_W-1:0] xp;
    logic signed [bec_pkg::X_W-1:0] yp;
    logic signed [bec_pkg::Z_W-1:0] zp;

    if (i == 0) begin : g_first
      assign xp = x_in;
      assign yp = y_in;
      assign zp = '0;
    end else begin : g_rest
      assign xp = xs[i-1];
      assign yp = ys[i-1];
      assign zp = zs[i-1];
    end

    // Rotate towards the x axis, accumulate the angle
    always_ff @(posedge clk) begin
      if (en[i]) begin
        if (!yp[bec_pkg::X_W-1]) begin
          xs[i] <= xp + (yp >>> i);
          ys[i] <= yp - (xp >>> i);
          zs[i] <= zp + ATAN;
        end else begin
          xs[i] <= xp - (yp >>> i);
          ys[i] <= yp + (xp >>> i);
          zs[i] <= zp - ATAN;
        end
      end
    end
  end

  assign x_out = xs[STEPS-1];
  assign z_out = zs[STEPS-1];

endmodule

FILE: src/bec_back.sv
// Back stages: speed scaling, angle of attack and the three coefficients.
module bec_back #(
  parameter int ANGLE_FRAC_BITS = bec_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic [bec_pkg::BACK_STAGES-1:0]   en,
  input  logic signed [bec_pkg::X_W-1:0]    xm,
  input  logic signed [bec_pkg::Z_W-1:0]    inflow,
  input  bec_pkg::side_t                    side,
  output logic [23:0]                       resultant_speed,
  output logic signed [16:0]                attack_angle,
  output logic signed [18:0]                lift_coef,
  output logic [15:0]                       drag_coef,
  output logic signed [16:0]                moment_coef
);

  localparam int AW  = 46;
  localparam int SH1 = 40 - ANGLE_FRAC_BITS;
  localparam logic signed [AW-1:0] RND1 = 46'sd1 <<< (SH1 - 1);
  localparam logic signed [AW-1:0] A_MAX = 46'sd65535;
  localparam logic signed [AW-1:0] A_MIN = -46'sd65536;
  localparam logic signed [20:0] L_MAX = 21'sd262143;
  localparam logic signed [20:0] L_MIN = -21'sd262144;

  logic [58:0]           e_sp;
  logic signed [AW-1:0]  e_aq;
  logic [23:0]           f_speed;
  logic signed [16:0]    f_a12;
  logic [23:0]           g_speed;
  logic signed [16:0]    g_a12;
  logic signed [36:0]    g_lp;
  logic signed [30:0]    g_mp;
  logic [32:0]           g_a2;

  logic [59:0]           sp_rnd;
  logic signed [AW-1:0]  a_afb;
  logic signed [AW-1:0]  a12_wide;
  logic signed [AW-1:0]  a12_clamp;
  logic signed [33:0]    a_sq;
  logic signed [36:0]    lp_rnd;
  logic signed [30:0]    mp_rnd;
  logic signed [20:0]    lift_w;
  logic signed [14:0]    mom_w;
  logic [45:0]           drag_w;

  // Stage E: gain correction product, pitch plus twist in radians less inflow
  always_ff @(posedge clk) begin
    if (en[0]) begin
      e_sp <= 59'(xm[34:0]) * 59'(bec_pkg::INV_GAIN_Q24);
      e_aq <= AW'(side.pt) * bec_pkg::DEG2RAD_Q40
              - (side.zero ? '0 : (AW'(inflow) <<< 10));
    end
  end

  // Round the angle to the working fraction, then to Q.12
  assign a_afb = (e_aq + RND1) >>> SH1;
  if (ANGLE_FRAC_BITS > 12) begin : g_down
    localparam logic signed [AW-1:0] RND2 = 46'sd1 <<< (ANGLE_FRAC_BITS - 13);
    assign a12_wide = (a_afb + RND2) >>> (ANGLE_FRAC_BITS - 12);
  end else if (ANGLE_FRAC_BITS == 12) begin : g_same
    assign a12_wide = a_afb;
  end else begin : g_up
    assign a12_wide = a_afb <<< (12 - ANGLE_FRAC_BITS);
  end

  assign a12_clamp = (a12_wide > A_MAX) ? A_MAX :
                     (a12_wide < A_MIN) ? A_MIN : a12_wide;
  assign sp_rnd    = 60'(e_sp) + (60'd1 << 31);

  // Stage F: round and saturate speed and angle
  always_ff @(posedge clk) begin
    if (en[1]) begin
      f_speed <= (|sp_rnd[59:56]) ? 24'hFFFFFF : sp_rnd[55:32];
      f_a12   <= a12_clamp[16:0];
    end
  end

  assign a_sq = 34'(f_a12) * 34'(f_a12);

  // Stage G: lift, moment and square products
  always_ff @(posedge clk) begin
    if (en[2]) begin
      g_speed <= f_speed;
      g_a12   <= f_a12;
      g_lp    <= 37'(f_a12) * bec_pkg::TWO_PI_Q16;
      g_mp    <= 31'(f_a12) * bec_pkg::NEG_MOMENT_Q16;
      g_a2    <= a_sq[32:0];
    end
  end

  assign lp_rnd = (g_lp + 37'sd32768) >>> 16;
  assign mp_rnd = (g_mp + 31'sd32768) >>> 16;
  assign lift_w = lp_rnd[20:0];
  assign mom_w  = mp_rnd[14:0];
  assign drag_w = 46'(g_a2) * bec_pkg::DRAG_K_Q16 + bec_pkg::DRAG_C_Q40
                  + (46'd1 << 27);

  // Stage H: round and saturate into the result register
  always_ff @(posedge clk) begin
    if (en[3]) begin
      resultant_speed <= g_speed;
      attack_angle    <= g_a12;
      lift_coef       <= (lift_w > L_MAX) ? L_MAX[18:0] :
                         (lift_w < L_MIN) ? L_MIN[18:0] : lift_w[18:0];
      drag_coef       <= (|drag_w[45:44]) ? 16'hFFFF : drag_w[43:28];
      moment_coef     <= 17'(mom_w);
    end
  end

endmodule

FILE: test/bec_checker.sv
// Result checker for the blade element coefficient core: predicts and compares.
`timescale 1ns / 100ps

module bec_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        radius,
  input  logic               item_valid,
  input  logic               item_stall,
  input  logic [15:0]        rotor_rpm,
  input  logic signed [15:0] fwd_airspeed,
  input  logic signed [15:0] vert_airspeed,
  input  logic [15:0]        radial_fraction,
  input  logic signed [15:0] pitch_deg,
  input  logic signed [15:0] twist_deg,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic [23:0]        resultant_speed,
  input  logic signed [16:0] attack_angle,
  input  logic signed [18:0] lift_coef,
  input  logic [15:0]        drag_coef,
  input  logic signed [16:0] moment_coef,
  output int                 fail_count,
  output int                 pending,
  output int                 result_count
);
  localparam int STEPS = 16;
  localparam int AFB   = 12;

  typedef struct packed {
    logic [23:0]        speed;
    logic signed [16:0] alpha;
    logic signed [18:0] lift;
    logic [15:0]        drag;
    logic signed [16:0] moment;
  } coef_t;

  coef_t coef_q[$];
  longint atan_tab[24] = '{843314857, 497837829, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  assign pending = coef_q.size();

  // Half-up rounding shift; >>> on longint floors
  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Vectoring rotation; returns final x, angle in Q30 through ang
  function automatic longint vector_rotate(longint x, longint y, output longint ang);
    longint dx, dy;
    ang = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; ang += atan_tab[i];
      end else begin
        x -= dx; y += dy; ang -= atan_tab[i];
      end
    end
    return x;
  endfunction

  function automatic coef_t element_coefs(logic [15:0] rpm, logic signed [15:0] fwd,
      logic signed [15:0] vert, logic [15:0] frac, logic signed [15:0] pitch,
      logic signed [15:0] twist, logic [15:0] rad);
    coef_t c;
    logic [63:0] p, hi, lo, vtu, a2, drg;
    longint vt, xm, dummy, inflow, aq, a, spd, af, lift, mom;
    p = 64'(rpm) * 64'(frac) * 64'(rad);
    hi = p >> 24;
    lo = p & 64'hFFFFFF;
    vtu = (hi * 64'd1756906 + ((lo * 64'd1756906) >> 24)) >> 20;
    vt = longint'(vtu);
    xm = vector_rotate(vt * 256, (fwd < 0 ? -longint'(fwd) : longint'(fwd)) * 256, dummy);
    spd = (xm * 10188013 + (longint'(1) << 31)) >>> 32;
    if (spd > 24'hFFFFFF) spd = 24'hFFFFFF;
    // zero vector gives zero inflow
    if (vt == 0 && vert == 0) inflow = 0;
    else xm = vector_rotate(vt * 256, longint'(vert) * 256, inflow);
    aq = (longint'(pitch) + longint'(twist)) * 74961321 - inflow * 1024;
    af = round_shift(aq, 40 - AFB);
    a = (AFB >= 12) ? round_shift(af, AFB - 12) : af * (longint'(1) << (12 - AFB));
    a = clip(a, -65536, 65535);
    lift = clip(round_shift(a * 411775, 16), -262144, 262143);
    a2 = 64'(a * a);
    drg = (a2 * 64'd3277 + 64'd10995116278 + (64'd1 << 27)) >> 28;
    if (drg > 64'hFFFF) drg = 64'hFFFF;
    mom = clip(round_shift(-a * 6554, 16), -65536, 65535);
    c.speed = spd[23:0];
    c.alpha = a[16:0];
    c.lift = lift[18:0];
    c.drag = drg[15:0];
    c.moment = mom[16:0];
    return c;
  endfunction

  // Predict on item transfer, compare on result transfer
  always @(posedge clk) begin
    coef_t want;
    if (rst) begin
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (item_valid && !item_stall)
        coef_q = {coef_q, element_coefs(rotor_rpm, fwd_airspeed, vert_airspeed,
                                        radial_fraction, pitch_deg, twist_deg, radius)};
      if (result_valid && !result_stall) begin
        result_count <= result_count + 1;
        if (coef_q.size() == 0) begin
          $display("%0t: result with nothing expected", $time);
          fail_count <= fail_count + 1;
        end else begin
          want = coef_q.pop_front();
          if (want.speed !== resultant_speed || want.alpha !== attack_angle ||
              want.lift !== lift_coef || want.drag !== drag_coef ||
              want.moment !== moment_coef) begin
            $display("%0t: mismatch exp spd %0d a %0d l %0d d %0d m %0d", $time,
                     want.speed, want.alpha, want.lift, want.drag, want.moment);
            $display("%0t:          got spd %0d a %0d l %0d d %0d m %0d", $time,
                     resultant_speed, attack_angle, lift_coef, drag_coef, moment_coef);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: test/tb.sv
// Stimulus and verdict for the blade element coefficient core.
`timescale 1ns / 100ps

module tb;

  localparam int LATENCY = 40;
  localparam int RAND_ITEMS = 1200;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic item_valid = 0, item_stall;
  logic [15:0] rotor_rpm = '0, radial_fraction = '0;
  logic signed [15:0] fwd_airspeed = '0, vert_airspeed = '0, pitch_deg = '0, twist_deg = '0;
  logic result_valid, result_stall = 0;
  logic [23:0] resultant_speed;
  logic signed [16:0] attack_angle, moment_coef;
  logic signed [18:0] lift_coef;
  logic [15:0] drag_coef;
  logic [15:0] radius_shadow = bec_pkg::RADIUS_RESET;
  int fail_count, pending, result_count;
  bit calm = 0;        // no idling in the closing stretch
  bit hold_off = 0;    // long receiver hold-off request
  longint cycle_count = 0;

  blade_element_aero_coefficients_core dut (.*);

  bec_checker chk (.clk, .rst, .radius(radius_shadow), .item_valid, .item_stall,
    .rotor_rpm, .fwd_airspeed, .vert_airspeed, .radial_fraction, .pitch_deg,
    .twist_deg, .result_valid, .result_stall, .resultant_speed, .attack_angle,
    .lift_coef, .drag_coef, .moment_coef, .fail_count, .pending, .result_count);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Abort on a runaway run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    wait (!rst);
    forever begin
      if (hold_off) begin
        @(negedge clk) result_stall <= 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end else if (!calm && $urandom_range(3) == 0) begin
        n = $urandom_range(1, 15);
        @(negedge clk) result_stall <= 1;
        repeat (n - 1) @(negedge clk);
      end else begin
        n = $urandom_range(1, 15);
        @(negedge clk) result_stall <= 0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  task automatic reg_write(logic [15:0] v);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= 3'(4 * bec_pkg::REG_RADIUS); pwdata <= {16'h0, v};
    @(negedge clk) penable <= 1;
    @(posedge clk);
    radius_shadow = v;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // Offer one element; hold it until transferred
  task automatic send_element(logic [15:0] rpm, logic [15:0] fwd, logic [15:0] vert,
                              logic [15:0] frac, logic [15:0] pitch, logic [15:0] twist);
    int gap;
    if (!calm && $urandom_range(4) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk) item_valid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1;
    rotor_rpm <= rpm; fwd_airspeed <= fwd; vert_airspeed <= vert;
    radial_fraction <= frac; pitch_deg <= pitch; twist_deg <= twist;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic drain;
    @(negedge clk) item_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic send_random;
    logic [15:0] r, f;
    case ($urandom_range(4))
      0: begin r = 16'($urandom_range(0, 2000)); f = 16'($urandom_range(0, 65535)); end
      1: begin r = 16'hFFFF - 16'($urandom_range(0, 255)); f = 16'($urandom); end
      2: begin r = 16'($urandom); f = 16'($urandom_range(0, 3)); end
      default: begin r = 16'($urandom); f = 16'($urandom); end
    endcase
    send_element(r, 16'($urandom), ($urandom_range(7) == 0) ? 16'h0 : 16'($urandom), f,
                 $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8000)),
                 $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4000)));
  endtask

  logic [15:0] radius_set[4] = '{16'd0, 16'hFFFF, 16'd100, 16'd2560};

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 0;
    // directed: extremes, zero vector, zero tangential speed, saturation
    send_element(0, 0, 0, 0, 0, 0);
    send_element(0, 0, 16'h7FFF, 0, 0, 0);
    send_element(0, 0, 16'h8000, 0, 0, 0);
    send_element(0, 16'h8000, 16'h0100, 16'hFFFF, 16'h7FFF, 16'h7FFF);
    send_element(16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h8000, 16'h8000);
    send_element(16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h8000);
    send_element(16'd4800, 16'd5120, 16'hFF00, 16'h8000, 16'd2048, 16'd512);
    send_element(16'd1, 16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 16'd1);
    send_element(16'd1, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_element(16'h8000, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    drain();
    // random phases across radius settings, extremes among them
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(radius_set[ph]);
      for (int i = 0; i < RAND_ITEMS / 4; i++) begin
        if (ph == 1 && i == 50) hold_off = 1;
        if (ph == 3 && i > RAND_ITEMS / 8) calm = 1;
        send_random();
      end
      drain();
    end
    $display("Covered %0d results over four rotor radius settings incl. 0 and 65535,",
             result_count);
    $display("with random stalls, gaps and a long receiver hold-off.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+src
src/bec_pkg.sv
src/bec_front.sv
src/bec_cordic.sv
src/bec_back.sv
src/blade_element_aero_coefficients_core.sv
test/bec_checker.sv
test/tb.sv
